/* rtl/mipft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mipft_pkg: shared definitions for the masked IPv4 filter table
// Command and status codes, the stored entry layout, the sequencer states
// and the octet mask helpers used by the datapath and the checker.
// ----------------------------------------------------------------------------
package mipft_pkg;

    // Command codes carried on the cmd port.
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int unsigned APB_AW             = 3;
    localparam int unsigned APB_DW             = 32;
    localparam logic        REG_BLOCK_ON_MATCH = 1'b0;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned GAMES_W   = 16;
    localparam int unsigned ENTRIES_W = 11;

    localparam logic [7:0] OCTET_ONES = 8'hff;

    // The octet mask of an entry is a function of its compare address
    // (a bit is set where the stored octet is non-zero), so only the
    // address and the games count are stored.
    typedef struct packed {
        logic [ADDR_W-1:0]  compare;
        logic [GAMES_W-1:0] games;
    } entry_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DONE
    } seq_state_t;

    function automatic logic [3:0] octet_mask_of(input logic [ADDR_W-1:0] addr);
        logic [3:0] m;
        m[3] = |addr[31:24];
        m[2] = |addr[23:16];
        m[1] = |addr[15:8];
        m[0] = |addr[7:0];
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] expand_mask(input logic [3:0] m);
        logic [ADDR_W-1:0] w;
        w = {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}} & {4{OCTET_ONES}};
        return w;
    endfunction

endpackage : mipft_pkg
`default_nettype wire

/* rtl/mipft_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mipft_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mipft_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mipft_ram
`default_nettype wire

/* rtl/masked_ip_filter_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// masked_ip_filter_table: ordered IPv4 access control list
// Keeps a packed table of masked filter entries in one RAM and answers
// lookup, add, remove and game-end tick commands, one result per command.
// ----------------------------------------------------------------------------
// Usage:
// An item is a transfer on the input channel (in_valid/in_ready) carrying
// cmd, address and ban_games. Every item yields exactly one result transfer
// on the output channel (out_valid/out_ready) with status, blocked, matched,
// games_left and entries_used. Items are worked one at a time, in order.
// An add writes the next free slot and goes straight to the result step.
// Lookup, remove and tick walk the table through the single RAM read port,
// one entry per cycle, and then raise out_valid; a lookup that matches an
// entry stops the walk early. Remove and tick compact the table in the
// same pass: each kept entry is written back in the cycle after it is
// read, always at an index no higher than the one being read.
// The result sits in an output register; the next item is accepted while
// it waits, and a finished item holds in its last step until the receiver
// takes the previous result. Reset empties the table (the fill count goes
// to zero, no clearing pass is needed) and sets block_on_match to 1.
// block_on_match is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module masked_ip_filter_table
    import mipft_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            cmd,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [GAMES_W-1:0]    ban_games,
    // Result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic                       blocked,
    output logic                       matched,
    output logic [GAMES_W-1:0]         games_left,
    output logic [ENTRIES_W-1:0]       entries_used,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENT_W = $bits(entry_t);

    // Control state.
    seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                block_on_match_reg, block_on_match_next;

    // Working registers of the current item.
    cmd_t                op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    wr_idx_reg, wr_idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic [GAMES_W-1:0]  games_reg, games_next;

    // Result register.
    logic [1:0]          status_reg, status_next;
    logic                blocked_reg, blocked_next;
    logic                matched_reg, matched_next;
    logic [GAMES_W-1:0]  games_left_reg, games_left_next;
    logic [ENTRIES_W-1:0] entries_used_reg, entries_used_next;

    // RAM ports.
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    entry_t              ram_rd_data;

    logic                accept;
    logic                issue;
    logic                not_full;
    logic                cfg_write;

    mipft_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The APB port has one register; the byte offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1] == REG_BLOCK_ON_MATCH);

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_BLOCK_ON_MATCH)
        begin
            prdata[0] = block_on_match_reg;
        end
    end

    always_comb
    begin
        block_on_match_next = block_on_match_reg;
        if (cfg_write)
        begin
            block_on_match_next = pwdata[0];
        end
    end

    assign in_ready = (state_reg == SEQ_IDLE);
    assign accept   = in_valid && in_ready;
    assign not_full = (count_reg < CNT_W'(TABLE_DEPTH));
    // During a scan, a read goes out each cycle until the whole table is covered.
    assign issue    = (rd_idx_reg < count_reg);

    // Sequencer: next state, RAM control and the result assembly.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg;
        op_next           = op_reg;
        addr_next         = addr_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        pend_next         = pend_reg;
        found_next        = found_reg;
        games_next        = games_reg;
        status_next       = status_reg;
        blocked_next      = blocked_reg;
        matched_next      = matched_reg;
        games_left_next   = games_left_reg;
        entries_used_next = entries_used_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_idx_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg[AW-1:0];

        // The result register drains independently of the sequencer.
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd_t'(cmd);
                    addr_next   = address;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    games_next  = '0;
                    if (cmd_t'(cmd) == CMD_ADD)
                    begin
                        // Append at the fill count; found marks success.
                        if (not_full)
                        begin
                            ram_wr_en           = 1'b1;
                            ram_wr_addr         = count_reg[AW-1:0];
                            ram_wr_data.compare = address;
                            ram_wr_data.games   = ban_games;
                            count_next          = count_reg + CNT_W'(1);
                            found_next          = 1'b1;
                        end
                        state_next = SEQ_DONE;
                    end
                    else
                    begin
                        state_next = SEQ_SCAN;
                    end
                end
            end

            SEQ_SCAN:
            begin
                ram_rd_en = issue;
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end

                if (pend_reg)
                begin
                    unique case (op_reg)
                        CMD_LOOKUP:
                        begin
                            if ((addr_reg & expand_mask(octet_mask_of(ram_rd_data.compare)))
                                == ram_rd_data.compare)
                            begin
                                found_next = 1'b1;
                                games_next = ram_rd_data.games;
                                state_next = SEQ_DONE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // The first exact match is dropped; every later
                            // entry moves down by one slot.
                            if (!found_reg && (ram_rd_data.compare == addr_reg))
                            begin
                                found_next = 1'b1;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                wr_idx_next = wr_idx_reg + CNT_W'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            // Permanent entries are kept as they are; timed
                            // entries count down and leave when they reach zero.
                            if (ram_rd_data.games != GAMES_W'(1))
                            begin
                                ram_wr_en   = 1'b1;
                                wr_idx_next = wr_idx_reg + CNT_W'(1);
                                if (ram_rd_data.games != '0)
                                begin
                                    ram_wr_data.games = ram_rd_data.games - GAMES_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (!issue)
                begin
                    // Table walked to the end with nothing in flight.
                    state_next = SEQ_DONE;
                    if (op_reg != CMD_LOOKUP)
                    begin
                        count_next = wr_idx_reg;
                    end
                end
            end

            SEQ_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = ST_DONE;
                    blocked_next      = 1'b0;
                    matched_next      = 1'b0;
                    games_left_next   = '0;
                    entries_used_next = ENTRIES_W'(count_reg);
                    unique case (op_reg)
                        CMD_LOOKUP:
                        begin
                            matched_next    = found_reg;
                            games_left_next = games_reg;
                            blocked_next    = found_reg ? block_on_match_reg
                                                        : !block_on_match_reg;
                        end
                        CMD_ADD:
                        begin
                            status_next = found_reg ? ST_DONE : ST_FULL;
                        end
                        CMD_REMOVE:
                        begin
                            status_next = found_reg ? ST_DONE : ST_NOT_FOUND;
                        end
                        CMD_TICK:
                        begin
                            status_next = ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= SEQ_IDLE;
            count_reg          <= '0;
            out_valid_reg      <= 1'b0;
            block_on_match_reg <= 1'b1;
            pend_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            out_valid_reg      <= out_valid_next;
            block_on_match_reg <= block_on_match_next;
            pend_reg           <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        addr_reg         <= addr_next;
        rd_idx_reg       <= rd_idx_next;
        wr_idx_reg       <= wr_idx_next;
        found_reg        <= found_next;
        games_reg        <= games_next;
        status_reg       <= status_next;
        blocked_reg      <= blocked_next;
        matched_reg      <= matched_next;
        games_left_reg   <= games_left_next;
        entries_used_reg <= entries_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign blocked      = blocked_reg;
    assign matched      = matched_reg;
    assign games_left   = games_left_reg;
    assign entries_used = entries_used_reg;

endmodule : masked_ip_filter_table
`default_nettype wire

/* rtl/mipft_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mipft_checker: port-level checks for the masked IPv4 filter table
// Watches the command and result channels of the top level over time.
// ----------------------------------------------------------------------------
module mipft_checker
    import mipft_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [1:0]           status,
    input wire logic                 blocked,
    input wire logic                 matched,
    input wire logic [GAMES_W-1:0]   games_left,
    input wire logic [ENTRIES_W-1:0] entries_used
);

    // A stalled result holds still until the receiver takes it.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(blocked)
            && $stable(matched) && $stable(games_left) && $stable(entries_used))
        else $error("result changed while stalled");

    // Items are worked one at a time: the engine is busy right after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    // Without a match there is no games count to report.
    a_no_match_no_games: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> games_left == '0)
        else $error("games_left set without a match");

    // Failed adds and removes carry no lookup verdict.
    a_error_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_NOT_FOUND) |-> !matched && !blocked)
        else $error("lookup fields set on a failed table update");

endmodule : mipft_checker

bind masked_ip_filter_table mipft_checker u_mipft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .blocked      (blocked),
    .matched      (matched),
    .games_left   (games_left),
    .entries_used (entries_used)
);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the masked IPv4 filter table
// Drives lookup, add, remove and game-end tick commands with random gaps and
// stalls. Results are checked against directed rows or an in-bench model.
// The run covers both filter modes and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import mipft_pkg::*;

    localparam int unsigned TABLE_SLOTS = 1024;
    localparam int unsigned RANDOM_PHASES = 4;
    localparam int unsigned PHASE_ITEMS = 132;
    localparam int unsigned GROWTH_CAP = 256;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam logic [APB_AW-1:0] MODE_REG_ADDR = APB_AW'(4 * REG_BLOCK_ON_MATCH);

    // One command as it travels on the input channel.
    typedef struct packed {
        cmd_t               op;
        logic [31:0]        addr;
        logic [15:0]        games;
    } filter_item_t;

    // One result as it comes back on the output channel.
    typedef struct packed {
        logic [1:0]         status;
        logic               blocked;
        logic               matched;
        logic [15:0]        left;
        logic [10:0]        used;
    } filter_result_t;

    // A row of the directed table. Where known is set, the typed result is
    // the expectation; otherwise the table model supplies it.
    typedef struct {
        filter_item_t       item;
        bit                 known;
        filter_result_t     want;
    } filter_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             cmd;
    logic [31:0]            address;
    logic [15:0]            ban_games;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status;
    logic                   blocked;
    logic                   matched;
    logic [15:0]            games_left;
    logic [10:0]            entries_used;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Mirror of the filter table and of the mode register.
    logic [31:0]            table_addr [TABLE_SLOTS];
    logic [3:0]             table_mask [TABLE_SLOTS];
    logic [15:0]            table_games [TABLE_SLOTS];
    int unsigned            table_used;
    logic                   refuse_on_match;

    // Results owed by the block, oldest first.
    filter_result_t         pending_results [$];
    int unsigned            error_count;

    // Flow control between the stimulus and the receiver.
    bit                     idle_off;
    bit                     hold_request;
    int unsigned            hold_left;

    // Directed opening sequence. The table starts empty and the block
    // refuses matching addresses, so the first rows can be read off by eye.
    filter_row_t directed_rows [21] = '{
        '{'{CMD_LOOKUP, 32'h01020304, 16'h0000}, 1'b1, '{ST_DONE, 1'b0, 1'b0, 16'h0000, 11'd0}},
        '{'{CMD_REMOVE, 32'h01020304, 16'h0000}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 16'h0000, 11'd0}},
        '{'{CMD_TICK, 32'h00000000, 16'h0000}, 1'b1, '{ST_DONE, 1'b0, 1'b0, 16'h0000, 11'd0}},
        '{'{CMD_ADD, 32'hffffffff, 16'hffff}, 1'b1, '{ST_DONE, 1'b0, 1'b0, 16'h0000, 11'd1}},
        '{'{CMD_LOOKUP, 32'hffffffff, 16'hffff}, 1'b1, '{ST_DONE, 1'b1, 1'b1, 16'hffff, 11'd1}},
        '{'{CMD_ADD, 32'h0a000000, 16'h0000}, 1'b1, '{ST_DONE, 1'b0, 1'b0, 16'h0000, 11'd2}},
        '{'{CMD_LOOKUP, 32'h0a123456, 16'h5a5a}, 1'b0, '0},
        '{'{CMD_ADD, 32'h00000000, 16'h0001}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h12345678, 16'h0000}, 1'b0, '0},
        '{'{CMD_ADD, 32'h0a000000, 16'h0005}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'h0a000000, 16'ha5a5}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h0a000001, 16'h0000}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'h0a0000ff, 16'h0000}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 16'h0000, 11'd3}},
        '{'{CMD_TICK, 32'hffffffff, 16'hffff}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h0a000000, 16'h0000}, 1'b0, '0},
        '{'{CMD_ADD, 32'h00ff00ff, 16'h8000}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h01ff02ff, 16'h0000}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'hffffffff, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK, 32'h00000000, 16'h0000}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h00000000, 16'h0000}, 1'b0, '0},
        '{'{CMD_ADD, 32'h80808080, 16'h7fff}, 1'b0, '0}
    };

    masked_ip_filter_table #(
        .TABLE_DEPTH    (TABLE_SLOTS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .address        (address),
        .ban_games      (ban_games),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .blocked        (blocked),
        .matched        (matched),
        .games_left     (games_left),
        .entries_used   (entries_used),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // A bit of the octet mask is set where the octet is non-zero. Bit 3
    // belongs to the first octet, which sits in address bits 31:24.
    function automatic logic [3:0] wildcard_bits(input logic [31:0] addr);
        logic [3:0] m;
        for (int o = 0; o < 4; o++)
            m[o] = (addr[8*o +: 8] != 8'h00);
        return m;
    endfunction

    // Widens an octet mask to the 32 address bits that it covers.
    function automatic logic [31:0] octet_span(input logic [3:0] m);
        logic [31:0] w;
        for (int o = 0; o < 4; o++)
            w[8*o +: 8] = {8{m[o]}};
        return w;
    endfunction

    // Removes one entry and slides the rest down to keep the table packed.
    function automatic void drop_entry(input int unsigned idx);
        for (int unsigned j = idx + 1; j < table_used; j++)
        begin
            table_addr[j-1] = table_addr[j];
            table_mask[j-1] = table_mask[j];
            table_games[j-1] = table_games[j];
        end
        table_used--;
    endfunction

    // Applies one command to the mirrored table and returns the result
    // that the block has to produce for it.
    function automatic filter_result_t apply_filter_cmd(input filter_item_t it);
        filter_result_t r;
        logic [3:0] m;
        int unsigned i;
        r = '0;
        m = wildcard_bits(it.addr);
        case (it.op)
            CMD_LOOKUP:
            begin
                // The first entry that agrees on its non-wildcard octets wins.
                for (i = 0; i < table_used; i++)
                begin
                    if ((it.addr & octet_span(table_mask[i])) == table_addr[i])
                    begin
                        r.matched = 1'b1;
                        r.left = table_games[i];
                        break;
                    end
                end
                r.blocked = r.matched ? refuse_on_match : !refuse_on_match;
            end
            CMD_ADD:
            begin
                if (table_used >= TABLE_SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    table_addr[table_used] = it.addr;
                    table_mask[table_used] = m;
                    table_games[table_used] = it.games;
                    table_used++;
                end
            end
            CMD_REMOVE:
            begin
                // Only an exact match on address and mask is removed.
                r.status = ST_NOT_FOUND;
                for (i = 0; i < table_used; i++)
                begin
                    if (table_addr[i] == it.addr && table_mask[i] == m)
                    begin
                        drop_entry(i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            default:
            begin
                // Timed entries count down; those that reach zero leave the
                // table. Permanent entries, with a count of zero, stay.
                i = 0;
                while (i < table_used)
                begin
                    if (table_games[i] != 16'h0000)
                    begin
                        table_games[i]--;
                        if (table_games[i] == 16'h0000)
                        begin
                            drop_entry(i);
                            continue;
                        end
                    end
                    i++;
                end
            end
        endcase
        r.used = table_used[10:0];
        return r;
    endfunction

    // Addresses are built octet by octet from a small alphabet, so that
    // wildcards, all-ones octets and repeated values are common and adds,
    // lookups and removes keep running into one another.
    function automatic logic [31:0] random_address();
        logic [31:0] a;
        int unsigned pick;
        for (int o = 0; o < 4; o++)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                a[8*o +: 8] = 8'h00;
            else if (pick == 3)
                a[8*o +: 8] = 8'hff;
            else if (pick < 6)
                a[8*o +: 8] = 8'($urandom_range(4, 1));
            else
                a[8*o +: 8] = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 15)
            a = $urandom();
        return a;
    endfunction

    // Mostly short bans so that ticks expire entries often, with some
    // permanent ones and a spread of long ones.
    function automatic logic [15:0] random_games();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return 16'h0000;
        else if (pick < 75)
            return 16'($urandom_range(4, 1));
        else if (pick < 95)
            return 16'($urandom_range(16'hffff));
        else
            return 16'hffff;
    endfunction

    // Picks the next command. Lookups and removes usually aim at a listed
    // entry so that hits and real deletions dominate. With capped set, adds
    // turn into lookups once the table holds GROWTH_CAP entries, which keeps
    // the walks short.
    function automatic filter_item_t random_command(input bit capped);
        filter_item_t it;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        it.addr = random_address();
        it.games = 16'($urandom_range(16'hffff));
        k = (table_used > 0) ? $urandom_range(table_used - 1) : 0;
        if (pick < 35 || (pick < 65 && capped && table_used >= GROWTH_CAP))
        begin
            it.op = CMD_LOOKUP;
            if (table_used > 0 && $urandom_range(99) < 60)
                it.addr = table_addr[k] | ($urandom() & ~octet_span(table_mask[k]));
        end
        else if (pick < 65)
        begin
            it.op = CMD_ADD;
            it.games = random_games();
        end
        else if (pick < 82)
        begin
            it.op = CMD_REMOVE;
            if (table_used > 0 && $urandom_range(99) < 70)
                it.addr = table_addr[k];
        end
        else
            it.op = CMD_TICK;
        return it;
    endfunction

    // Offers one command, waits for its transfer and books the expected
    // result at the edge where the block takes it.
    task automatic send_command(input filter_item_t it, input bit known,
                                input filter_result_t want);
        filter_result_t predicted;
        @(negedge clk);
        while (!idle_off && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.op;
        address <= it.addr;
        ban_games <= it.games;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_filter_cmd(it);
        pending_results.push_back(known ? want : predicted);
    endtask

    // Lowers valid and waits until every booked result has come back, so
    // that the block is idle before the mode register changes.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer: a setup cycle, then an access cycle that completes
    // at the rising edge where pready is high.
    task automatic apb_transfer(input bit wr, input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MODE_REG_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Writes the mode register, reads it back and updates the mirror.
    task automatic set_block_on_match(input logic value);
        logic [APB_DW-1:0] readback;
        apb_transfer(1'b1, APB_DW'(value), readback);
        refuse_on_match = value;
        apb_transfer(1'b0, '0, readback);
        check_field("block_on_match", APB_DW'(value), readback);
    endtask

    // Receiver. It stalls about one cycle in five, not at all while the
    // stimulus runs with idling off, and once for HOLD_CYCLES in a row
    // so that the output register fills and the input channel backs up.
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= idle_off || ($urandom_range(99) >= 20);
        end
    end

    // Result checker. Each result transfer is matched with the oldest
    // booked expectation, field by field.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result with no command outstanding, status %0h used %0d",
                         $time, status, entries_used);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("blocked", 32'(want.blocked), 32'(blocked));
                check_field("matched", 32'(want.matched), 32'(matched));
                check_field("games_left", 32'(want.left), 32'(games_left));
                check_field("entries_used", 32'(want.used), 32'(entries_used));
            end
        end
    end

    // Main sequence: reset, directed rows, then random phases in both modes.
    initial
    begin
        filter_item_t it;
        logic [APB_DW-1:0] readback;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOOKUP;
        address = '0;
        ban_games = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_off = 1'b0;
        hold_request = 1'b0;
        error_count = 0;
        table_used = 0;
        refuse_on_match = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The mode register comes out of reset refusing matches.
        apb_transfer(1'b0, '0, readback);
        check_field("block_on_match", APB_DW'(1), readback);

        foreach (directed_rows[r])
            send_command(directed_rows[r].item, directed_rows[r].known, directed_rows[r].want);

        // Random phases alternate the mode. The second runs with no idling
        // on either side, the third starts with the long receiver stall.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_block();
            set_block_on_match(p[0]);
            idle_off = (p == 1);
            if (p == 2)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = random_command(1'b1);
                send_command(it, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Give a stray extra result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("masked_ip_filter_table regression: pass");
        else
            $display("masked_ip_filter_table regression: fail");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #20_000_000;
        $display("masked_ip_filter_table regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/mipft_pkg.sv
rtl/mipft_ram.sv
rtl/masked_ip_filter_table.sv
rtl/mipft_checker.sv
test/testbench.sv
